// ----- rtl/assert_macros.svh -----
// assert_macros.svh: assertion macros shared by the box blur checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define BB3_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BB3_ASSERT_ANY(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bb3_pkg.sv -----
// bb3_pkg: types and constants shared by the 3x3 box blur modules.
// Depends on nothing; imported by the front, queue, back and top level.
`default_nettype none

package bb3_pkg;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int FRAME_SIZE_RESET = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int WIN_CELLS = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pixel;

    // Position of the current input relative to the frame borders.
    typedef struct packed {
        logic xp;   // column at least 1
        logic c2;   // column at least 2
        logic xc;   // last column
        logic yp;   // row at least 1
        logic r2;   // row at least 2
        logic yc;   // last row
    } t_edge_flags;

    // Window snapshot plus border flags: all the back end needs for a pixel.
    typedef struct packed {
        t_pixel [WIN_CELLS-1:0] win;
        t_edge_flags            flags;
    } t_job;

    typedef struct packed {
        logic              empty;
        logic [QLVL_W-1:0] level;
    } t_q_status;

endpackage

`default_nettype wire

// ----- rtl/bb3_front.sv -----
// bb3_front: frame counters, size registers, line store and 3x3 window.
// Depends on bb3_pkg; feeds jobs to bb3_queue.
`default_nettype none

module bb3_front #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bb3_pkg::CHAN_W-1:0]     i_in_red,
    input  logic [bb3_pkg::CHAN_W-1:0]     i_in_green,
    input  logic [bb3_pkg::CHAN_W-1:0]     i_in_blue,
    input  bb3_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output bb3_pkg::t_job                  o_job
);
    import bb3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_RESET = (FRAME_SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_SIZE_RESET;
    localparam int H_RESET = (FRAME_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_SIZE_RESET;
    localparam int MEM_W   = 2 * PIX_W;
    localparam int LVL_W   = QLVL_W + 1;

    logic [COL_W-1:0] r_w_last, n_w_last, cfg_w_last;
    logic [ROW_W-1:0] r_h_last, n_h_last, cfg_h_last;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             r_f1_valid;
    logic [COL_W-1:0] r_f1_col;
    t_pixel           r_f1_px;
    t_edge_flags      r_f1_flags;
    t_edge_flags      in_flags;

    t_pixel [WIN_CELLS-1:0] r_win, n_win;

    logic [MEM_W-1:0] r_mem [MAX_WIDTH];
    logic [MEM_W-1:0] r_rd_word;
    logic [MEM_W-1:0] r_byp_word;
    logic             r_byp;

    logic [LVL_W-1:0] occupancy;
    logic             accept;
    t_pixel           up1, up2;

    // A pixel is taken only if the queue can hold it and the one in flight.
    assign occupancy  = LVL_W'(i_q_status.level) + LVL_W'(r_f1_valid);
    assign o_in_stall = occupancy >= LVL_W'(QUEUE_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    // Effective frame size: zero counts as one, oversize is clamped.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w_last = '0;
            cfg_h_last = '0;
        end else begin
            cfg_w_last = (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1)
                                                             : COL_W'(i_cfg_data - 1'b1);
            cfg_h_last = (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT - 1)
                                                              : ROW_W'(i_cfg_data - 1'b1);
        end
    end

    always_comb begin
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        n_col    = r_col;
        n_row    = r_row;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  n_w_last = cfg_w_last;
                REG_FRAME_HEIGHT: n_h_last = cfg_h_last;
                default: ;
            endcase
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (r_col == r_w_last) begin
                n_col = '0;
                n_row = (r_row == r_h_last) ? '0 : ROW_W'(r_row + 1'b1);
            end else begin
                n_col = COL_W'(r_col + 1'b1);
            end
        end
    end

    always_comb begin
        in_flags.xp = (r_col != '0);
        in_flags.c2 = (r_col > COL_W'(1));
        in_flags.xc = (r_col == r_w_last);
        in_flags.yp = (r_row != '0);
        in_flags.r2 = (r_row > ROW_W'(1));
        in_flags.yc = (r_row == r_h_last);
    end

    // Back-to-back pixels in the same column (one pixel wide frames) see
    // the write of the previous pixel through the bypass word.
    assign up2 = r_byp ? r_byp_word[MEM_W-1:PIX_W] : r_rd_word[MEM_W-1:PIX_W];
    assign up1 = r_byp ? r_byp_word[PIX_W-1:0]     : r_rd_word[PIX_W-1:0];

    always_comb begin
        for (int i = 0; i < WIN_CELLS - 3; i++) begin
            n_win[i] = r_win[i+3];
        end
        n_win[WIN_CELLS-3] = up2;
        n_win[WIN_CELLS-2] = up1;
        n_win[WIN_CELLS-1] = r_f1_px;
    end

    assign o_push      = r_f1_valid && (r_f1_flags.xp || r_f1_flags.xc)
                                    && (r_f1_flags.yp || r_f1_flags.yc);
    assign o_job.win   = n_win;
    assign o_job.flags = r_f1_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last   <= COL_W'(W_RESET - 1);
            r_h_last   <= ROW_W'(H_RESET - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_w_last   <= n_w_last;
            r_h_last   <= n_h_last;
            r_col      <= n_col;
            r_row      <= n_row;
            r_f1_valid <= accept;
            if (r_f1_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_col   <= r_col;
            r_f1_px    <= {i_in_red, i_in_green, i_in_blue};
            r_f1_flags <= in_flags;
        end
    end

    // Line store: upper half is the older row, lower half the newer row.
    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_mem[r_f1_col] <= {up1, r_f1_px};
        end
        if (accept) begin
            r_rd_word  <= r_mem[r_col];
            r_byp      <= r_f1_valid && (r_f1_col == r_col);
            r_byp_word <= {up1, r_f1_px};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bb3_queue.sv -----
// bb3_queue: short job queue between the front and the back end.
// Depends on bb3_pkg for the job type and the depth.
`default_nettype none

module bb3_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bb3_pkg::t_job      i_job,
    input  logic               i_pop,
    output bb3_pkg::t_job      o_head,
    output bb3_pkg::t_q_status o_status
);
    import bb3_pkg::*;

    t_job              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QLVL_W-1:0] r_level, n_level;

    assign o_head          = r_entries[r_rd_ptr];
    assign o_status.level  = r_level;
    assign o_status.empty  = (r_level == '0);

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = QLVL_W'(r_level + 1'b1);
        end else if (i_pop && !i_push) begin
            n_level = QLVL_W'(r_level - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_level <= n_level;
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bb3_back.sv -----
// bb3_back: walks the results of each job, sums the clipped window and
// divides by the pixel count. Depends on bb3_pkg.
`default_nettype none

module bb3_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bb3_pkg::t_job              i_head,
    input  bb3_pkg::t_q_status         i_status,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [bb3_pkg::CHAN_W-1:0] o_out_red,
    output logic [bb3_pkg::CHAN_W-1:0] o_out_green,
    output logic [bb3_pkg::CHAN_W-1:0] o_out_blue,
    output logic                       o_out_run_last,
    output logic                       o_out_frame_last
);
    import bb3_pkg::*;

    localparam int SUM_W       = $clog2(WIN_CELLS * ((1 << CHAN_W) - 1) + 5);
    localparam int MULT_W      = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = SUM_W + MULT_W;
    localparam int CNT_W       = 4;

    // Result order within one job: upper-left, then down, then right.
    localparam logic [1:0] SEL_PREV_PREV = 2'd0;
    localparam logic [1:0] SEL_PREV_CUR  = 2'd1;
    localparam logic [1:0] SEL_CUR_PREV  = 2'd2;
    localparam logic [1:0] SEL_CUR_CUR   = 2'd3;

    typedef struct packed {
        logic [1:0]        shift;
        logic [MULT_W-1:0] mult;
    } t_div;

    // Count is 2^k * 3^m; shift out the power of two, then multiply by one or
    // by a reciprocal of 3 or 9 that is exact over the whole sum range.
    function automatic t_div div_of(input logic [CNT_W-1:0] cnt);
        t_div d;
        case (cnt)
            4'd2:    begin d.shift = 2'd1; d.mult = MULT_W'(32768); end
            4'd3:    begin d.shift = 2'd0; d.mult = MULT_W'(10923); end
            4'd4:    begin d.shift = 2'd2; d.mult = MULT_W'(32768); end
            4'd6:    begin d.shift = 2'd1; d.mult = MULT_W'(10923); end
            4'd9:    begin d.shift = 2'd0; d.mult = MULT_W'(3641);  end
            default: begin d.shift = 2'd0; d.mult = MULT_W'(32768); end
        endcase
        return d;
    endfunction

    logic       en, emit, last;
    logic [3:0] avail, pend, pick, r_done;
    logic [1:0] sel;
    logic [2:0] cmask, rmask;
    logic [1:0] ncol, nrow;
    logic [SUM_W-1:0] sums [3];

    logic                   r_s1_valid;
    logic [SUM_W-1:0]       r_s1_sum [3];
    logic [CNT_W-1:0]       r_s1_cnt;
    logic                   r_s1_run_last, r_s1_frame_last;

    logic                   r_s2_valid;
    logic [PROD_W-1:0]      r_s2_prod [3];
    logic [PROD_W-1:0]      n_prod [3];
    logic                   r_s2_run_last, r_s2_frame_last;
    t_div                   div;

    logic                   r_out_valid;
    logic [CHAN_W-1:0]      r_out_chan [3];
    logic                   r_out_run_last, r_out_frame_last;

    // The whole back end advances unless a finished result is held.
    assign en   = !(r_out_valid && i_out_stall);
    assign emit = en && !i_status.empty;

    assign avail = {i_head.flags.xc && i_head.flags.yc, i_head.flags.xc && i_head.flags.yp,
                    i_head.flags.xp && i_head.flags.yc, i_head.flags.xp && i_head.flags.yp};
    assign pend  = avail & ~r_done;

    always_comb begin
        if (pend[0]) begin
            sel = SEL_PREV_PREV;
        end else if (pend[1]) begin
            sel = SEL_PREV_CUR;
        end else if (pend[2]) begin
            sel = SEL_CUR_PREV;
        end else begin
            sel = SEL_CUR_CUR;
        end
    end

    assign pick  = 4'(1) << sel;
    assign last  = ((pend & ~pick) == '0);
    assign o_pop = emit && last;

    // Columns of the window (oldest first) and rows (oldest first) that
    // fall inside the frame for the chosen output position.
    assign cmask = sel[1] ? {1'b1, i_head.flags.xp, 1'b0} : {1'b1, 1'b1, i_head.flags.c2};
    assign rmask = sel[0] ? {1'b1, i_head.flags.yp, 1'b0} : {1'b1, 1'b1, i_head.flags.r2};
    assign ncol  = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
    assign nrow  = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sums[ch] = '0;
            for (int ia = 0; ia < 3; ia++) begin
                for (int ib = 0; ib < 3; ib++) begin
                    if (cmask[ia] && rmask[ib]) begin
                        sums[ch] = SUM_W'(sums[ch]
                                   + SUM_W'(i_head.win[ia*3+ib][(2-ch)*CHAN_W +: CHAN_W]));
                    end
                end
            end
        end
    end

    assign div = div_of(r_s1_cnt);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_prod[ch] = PROD_W'(SUM_W'(r_s1_sum[ch] + SUM_W'(r_s1_cnt >> 1)) >> div.shift)
                         * PROD_W'(div.mult);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= !i_status.empty;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (emit) begin
                r_done <= last ? '0 : (r_done | pick);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sum        <= sums;
            r_s1_cnt        <= CNT_W'(ncol) * CNT_W'(nrow);
            r_s1_run_last   <= last;
            r_s1_frame_last <= (sel == SEL_CUR_CUR);

            r_s2_prod       <= n_prod;
            r_s2_run_last   <= r_s1_run_last;
            r_s2_frame_last <= r_s1_frame_last;

            for (int ch = 0; ch < 3; ch++) begin
                r_out_chan[ch] <= r_s2_prod[ch][RECIP_SHIFT +: CHAN_W];
            end
            r_out_run_last   <= r_s2_run_last;
            r_out_frame_last <= r_s2_frame_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_red        = r_out_chan[0];
    assign o_out_green      = r_out_chan[1];
    assign o_out_blue       = r_out_chan[2];
    assign o_out_run_last   = r_out_run_last;
    assign o_out_frame_last = r_out_frame_last;

endmodule

`default_nettype wire

// ----- rtl/box_blur_3x3_rgb_core.sv -----
// box_blur_3x3_rgb_core: top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_front, bb3_queue and bb3_back.
`default_nettype none

// Streaming 3x3 box blur over RGB pixels sent in raster order. Each result
// is the per-channel mean of the 3x3 neighborhood clipped to the frame,
// rounded half up. The result for row r-1, column c-1 leaves after the
// pixel at row r, column c has been taken; the final row is flushed while
// the final input row streams in, so one input transfer can release up to
// four output transfers, the last of them flagged by o_out_run_last, and
// o_out_frame_last marks the bottom-right pixel. Rate: one pixel per clock
// over all rows but the last while o_in_stall is low; during the last row
// each pixel after the first releases two results and the row's last pixel
// four, and the divider pipeline in the back end produces one result per
// clock while its output is not held. A result passes the front stage, the
// queue and the sum, product and output registers. The line store is a
// single MAX_WIDTH-deep memory read into a register as the pixel is taken;
// it needs no clearing after reset, because border clipping never uses an
// entry that was not written earlier in the same frame. A short job queue
// parts the front (counters, line store, window) from the back end, so
// o_in_stall rises only when that queue, counting the pixel still in the
// front stage, holds four jobs. Writing frame_width or frame_height
// restarts the frame at its top-left pixel; write them only while no
// results are outstanding.
module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bb3_pkg::CHAN_W-1:0]    i_in_red,
    input  logic [bb3_pkg::CHAN_W-1:0]    i_in_green,
    input  logic [bb3_pkg::CHAN_W-1:0]    i_in_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bb3_pkg::CHAN_W-1:0]    o_out_red,
    output logic [bb3_pkg::CHAN_W-1:0]    o_out_green,
    output logic [bb3_pkg::CHAN_W-1:0]    o_out_blue,
    output logic                          o_out_run_last,
    output logic                          o_out_frame_last
);
    import bb3_pkg::*;

    // Jobs carry the window snapshot after each pixel plus its border
    // flags; pixels that release no result never enter the queue.
    logic      push, pop;
    t_job      job, head;
    t_q_status q_status;

    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (job)
    );

    bb3_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // The back end emits one result per clock and pops a job after its
    // last result; a held output freezes its whole pipeline.
    bb3_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_status         (q_status),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_out_run_last   (o_out_run_last),
        .o_out_frame_last (o_out_frame_last)
    );

endmodule

`default_nettype wire

// ----- rtl/bb3_checker.sv -----
// bb3_checker: port-level assertions for the box blur top level, bound in.
// Depends on assert_macros.svh and box_blur_3x3_rgb_core.
`default_nettype none
`include "assert_macros.svh"

module bb3_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [bb3_pkg::CHAN_W-1:0] o_out_red,
    input logic [bb3_pkg::CHAN_W-1:0] o_out_green,
    input logic [bb3_pkg::CHAN_W-1:0] o_out_blue,
    input logic                       o_out_run_last,
    input logic                       o_out_frame_last
);

    // The bottom-right pixel is always the final result of its input.
    `BB3_ASSERT(a_frame_last_ends_run, i_clk, i_rst_n, o_out_valid && o_out_frame_last |-> o_out_run_last, "frame_last without run_last")

    // Reset empties the queue and the result pipeline.
    `BB3_ASSERT_ANY(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "block not idle after reset")

    // A held result stays put until it is transferred.
    `BB3_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_run_last) && $stable(o_out_frame_last), "stalled result changed")

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_red        (o_out_red),
    .o_out_green      (o_out_green),
    .o_out_blue       (o_out_blue),
    .o_out_run_last   (o_out_run_last),
    .o_out_frame_last (o_out_frame_last)
);

`default_nettype wire
